// File: hdl/deque_pkg.sv
`timescale 1ns / 1ps

package deque_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

// File: hdl/double_ended_queue_with_search.sv
`timescale 1ns / 1ps

// channel | valid      | ready       | payload
// in      | i_in_valid | o_in_ready  | i_mode, i_value
// out     | o_out_valid| i_out_ready | o_popped_value, o_found, o_entry_count, o_status
//
// Push, refused push, pop on empty, search on empty and unused modes load the result register straight from idle.
// Pop: the memory read is registered first, then the word is loaded into the result register.
// Search: from the front, one stored word read and compared per cycle while the result register is free.
// One word at a time; input ready only while idle and the result register is free.
// Reset empties the queue; entry memory is not cleared.
// A stalled result holds every stage until it is taken.

module double_ended_queue_with_search #(
    parameter int DEPTH      = deque_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deque_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [deque_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [deque_pkg::VALUE_W-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [deque_pkg::VALUE_W-1:0] o_popped_value,
    output logic                                o_found,
    output logic [deque_pkg::COUNT_W-1:0]       o_entry_count,
    output logic [deque_pkg::STATUS_W-1:0]      o_status
);
    import deque_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = DATA_WIDTH;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    logic [1:0]          r_state, n_state;
    logic [AW-1:0]       r_front, n_front;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_left, n_left;
    logic [DW-1:0]       r_key, n_key;
    logic                r_rd_vld, n_rd_vld;
    logic [DW-1:0]       r_rd_data;
    logic                r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]  r_popped, n_popped;
    logic                r_found, n_found;
    logic [COUNT_W-1:0]  r_ecnt, n_ecnt;
    logic [STATUS_W-1:0] r_status, n_status;

    logic [DW-1:0] r_mem [DEPTH];

    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [DW-1:0]       in_data;
    logic                in_fire, out_free, full, empty;
    logic [AW-1:0]       front_dec, back_addr;
    logic [CW-1:0]       back_off;
    logic [AW:0]         back_sum;
    logic                ld, ld_found;
    logic [VALUE_W-1:0]  ld_pop;
    logic [CW-1:0]       ld_count;
    logic [STATUS_W-1:0] ld_status;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign in_data    = DW'($unsigned(i_value));
    assign front_dec  = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
    assign back_off   = (i_mode == MODE_POP_BACK) ? r_count - 1'b1 : r_count;
    assign back_sum   = (AW + 1)'(r_front) + (AW + 1)'(back_off);
    assign back_addr  = (back_sum >= (AW + 1)'(DEPTH)) ? AW'(back_sum - (AW + 1)'(DEPTH))
                                                      : AW'(back_sum);

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_key       = r_key;
        n_rd_vld    = r_rd_vld;
        n_out_valid = r_out_valid;
        n_popped    = r_popped;
        n_found     = r_found;
        n_ecnt      = r_ecnt;
        n_status    = r_status;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = back_addr;
        rd_addr     = r_ptr;
        ld          = 1'b0;
        ld_pop      = '0;
        ld_found    = 1'b0;
        ld_count    = r_count;
        ld_status   = STATUS_OK;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_key = in_data;
                    unique case (i_mode)
                        MODE_PUSH_BACK: begin
                            ld = 1'b1;
                            if (full) begin
                                ld_status = STATUS_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                n_count  = r_count + 1'b1;
                                ld_count = n_count;
                            end
                        end
                        MODE_PUSH_FRONT: begin
                            ld = 1'b1;
                            if (full) begin
                                ld_status = STATUS_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                wr_addr  = front_dec;
                                n_front  = front_dec;
                                n_count  = r_count + 1'b1;
                                ld_count = n_count;
                            end
                        end
                        MODE_POP_FRONT: begin
                            if (empty) begin
                                ld        = 1'b1;
                                ld_status = STATUS_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_front;
                                n_front = wrap_inc(r_front);
                                n_count = r_count - 1'b1;
                                n_state = S_POP;
                            end
                        end
                        MODE_POP_BACK: begin
                            if (empty) begin
                                ld        = 1'b1;
                                ld_status = STATUS_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = back_addr;
                                n_count = r_count - 1'b1;
                                n_state = S_POP;
                            end
                        end
                        MODE_SEARCH: begin
                            if (empty) begin
                                ld = 1'b1;
                            end else begin
                                n_ptr    = r_front;
                                n_left   = r_count;
                                n_rd_vld = 1'b0;
                                n_state  = S_SRCH;
                            end
                        end
                        default: begin
                            ld = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (out_free) begin
                    ld      = 1'b1;
                    ld_pop  = VALUE_W'(r_rd_data);
                    n_state = S_IDLE;
                end
            end
            S_SRCH: begin
                if (out_free) begin
                    if (r_rd_vld && (r_rd_data == r_key)) begin
                        ld       = 1'b1;
                        ld_found = 1'b1;
                        n_state  = S_IDLE;
                    end else if (r_left == '0) begin
                        ld      = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        // advance one stored word
                        rd_en    = 1'b1;
                        rd_addr  = r_ptr;
                        n_ptr    = wrap_inc(r_ptr);
                        n_left   = r_left - 1'b1;
                        n_rd_vld = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ld) begin
            n_out_valid = 1'b1;
            n_popped    = ld_pop;
            n_found     = ld_found;
            n_ecnt      = COUNT_W'(ld_count);
            n_status    = ld_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_left   <= n_left;
        r_key    <= n_key;
        r_popped <= n_popped;
        r_found  <= n_found;
        r_ecnt   <= n_ecnt;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= in_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = $signed(r_popped);
    assign o_found        = r_found;
    assign o_entry_count  = r_ecnt;
    assign o_status       = r_status;

endmodule

// File: hdl/deque_chk.sv
`timescale 1ns / 1ps

module deque_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [deque_pkg::VALUE_W-1:0] o_popped_value,
    input logic                                 o_found,
    input logic [deque_pkg::COUNT_W-1:0]        o_entry_count,
    input logic [deque_pkg::STATUS_W-1:0]       o_status
);
    import deque_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_popped_value)
            && $stable(o_found) && $stable(o_entry_count) && $stable(o_status))
        else $error("result word changed while stalled");

    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while result register is blocked");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_status == STATUS_OK && o_popped_value == '0)
        else $error("found flag with bad status or popped word");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STATUS_EMPTY || o_status == STATUS_FULL)
            |-> o_popped_value == '0 && !o_found)
        else $error("error status with nonzero result fields");

endmodule

bind double_ended_queue_with_search deque_chk u_deque_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_popped_value (o_popped_value),
    .o_found        (o_found),
    .o_entry_count  (o_entry_count),
    .o_status       (o_status)
);
